@@ design/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, codes and helpers for the HTTP request head parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    localparam int MAX_HEADERS_DEF = 32;
    localparam int COUNT_W         = 6;
    localparam int INDEX_W         = 5;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        CL_METHOD  = 3'd0,
        CL_URL     = 3'd1,
        CL_VERSION = 3'd2,
        CL_NAME    = 3'd3,
        CL_VALUE   = 3'd4,
        CL_PAYLOAD = 3'd5,
        CL_DELIM   = 3'd6
    } class_t;

    typedef enum logic [12:0] {
        PH_METHOD   = 13'b0000000000001,
        PH_URL      = 13'b0000000000010,
        PH_VERSION  = 13'b0000000000100,
        PH_VER_LF   = 13'b0000000001000,
        PH_LINE     = 13'b0000000010000,
        PH_NAME     = 13'b0000000100000,
        PH_COLON_SP = 13'b0000001000000,
        PH_SPACES   = 13'b0000010000000,
        PH_VALUE    = 13'b0000100000000,
        PH_VAL_LF   = 13'b0001000000000,
        PH_END_LF   = 13'b0010000000000,
        PH_PAYLOAD  = 13'b0100000000000,
        PH_ERROR    = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } req_t;

    typedef struct packed {
        class_t               cls;
        logic [INDEX_W-1:0]   idx;
        logic                 err;
        logic                 done;
        logic                 acc;
    } res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

@@ design/http_request_head_parser_top.sv @@
// ----------------------------------------------------------------------------
// http_request_head_parser_top
// Result path: an accepted byte is held in the input register, classified, then registered in the result register.
// Throughput: one byte per cycle while the result channel is not stalled.
// Input and result registers decouple the two channels.
// Reset: parser returns to method phase, header count and error flag clear.
// ----------------------------------------------------------------------------
module http_request_head_parser_top #(
    parameter int MAX_HEADERS_P = hrhp_pkg::MAX_HEADERS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [7:0] byte_in,
    input  logic       last,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] byte_class,
    output logic [4:0] header_index,
    output logic       error_seen,
    output logic       done_res,
    output logic       accepted
);

    hrhp_pkg::req_t req_data;
    hrhp_pkg::req_t held_data;
    hrhp_pkg::res_t res_comb;
    hrhp_pkg::res_t res_out;
    logic           held_valid;
    logic           advance;
    logic           advance_ok;

    assign req_data.byte_in = byte_in;
    assign req_data.last    = last;

    hrhp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .advance_ok (advance_ok),
        .held_valid (held_valid),
        .held_data  (held_data),
        .advance    (advance)
    );

    hrhp_classify #(
        .HDR_LIMIT (MAX_HEADERS_P)
    ) u_cls (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance && held_valid),
        .req     (held_data),
        .res     (res_comb)
    );

    hrhp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .res_in     (res_comb),
        .res_stall  (res_stall),
        .res_valid  (res_valid),
        .res_out    (res_out),
        .advance_ok (advance_ok)
    );

    assign byte_class   = res_out.cls;
    assign header_index = res_out.idx;
    assign error_seen   = res_out.err;
    assign done_res     = res_out.done;
    assign accepted     = res_out.acc;

endmodule

@@ design/hrhp_in_stage.sv @@
// ----------------------------------------------------------------------------
// hrhp_in_stage
// Input register: holds one request byte until the classifier takes it.
// ----------------------------------------------------------------------------
module hrhp_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  hrhp_pkg::req_t req_data,
    input  logic          advance_ok,
    output logic          held_valid,
    output hrhp_pkg::req_t held_data,
    output logic          advance
);

    logic           valid_reg;
    hrhp_pkg::req_t data_reg;
    logic           load;

    assign advance    = valid_reg && advance_ok;
    assign req_stall  = valid_reg && !advance_ok;
    assign load       = req_valid && !req_stall;
    assign held_valid = valid_reg;
    assign held_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= req_data;
        end
    end

endmodule

@@ design/hrhp_classify.sv @@
// ----------------------------------------------------------------------------
// hrhp_classify
// Per-byte syntax state machine: classifies the byte and gives the verdict.
// ----------------------------------------------------------------------------
module hrhp_classify #(
    parameter int HDR_LIMIT = hrhp_pkg::MAX_HEADERS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  hrhp_pkg::req_t req,
    output hrhp_pkg::res_t res
);

    hrhp_pkg::phase_t                  phase_reg;
    hrhp_pkg::phase_t                  phase_next;
    logic [hrhp_pkg::COUNT_W-1:0]      count_reg;
    logic [hrhp_pkg::COUNT_W-1:0]      count_next;
    logic                              error_reg;
    logic                              bad;
    logic                              payload_byte;
    logic                              err_now;
    hrhp_pkg::class_t                  cls;
    logic [hrhp_pkg::INDEX_W-1:0]      idx;
    logic [hrhp_pkg::INDEX_W-1:0]      cur_idx;
    logic                              full;
    logic [7:0]                        c;

    assign c       = req.byte_in;
    assign cur_idx = count_reg[hrhp_pkg::INDEX_W-1:0];
    assign full    = (count_reg >= hrhp_pkg::COUNT_W'(HDR_LIMIT));

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        bad          = 1'b0;
        payload_byte = 1'b0;
        cls          = hrhp_pkg::CL_DELIM;
        idx          = '0;
        unique case (phase_reg)
            hrhp_pkg::PH_METHOD, hrhp_pkg::PH_URL:
            begin
                if (c == hrhp_pkg::CH_SP)
                begin
                    phase_next = (phase_reg == hrhp_pkg::PH_METHOD) ? hrhp_pkg::PH_URL
                                                                    : hrhp_pkg::PH_VERSION;
                end
                else if (hrhp_pkg::is_ws(c))
                begin
                    bad = 1'b1;
                end
                else
                begin
                    cls = (phase_reg == hrhp_pkg::PH_METHOD) ? hrhp_pkg::CL_METHOD
                                                             : hrhp_pkg::CL_URL;
                end
            end
            hrhp_pkg::PH_VERSION:
            begin
                if (c == hrhp_pkg::CH_CR)
                begin
                    phase_next = hrhp_pkg::PH_VER_LF;
                end
                else
                begin
                    cls = hrhp_pkg::CL_VERSION;
                end
            end
            hrhp_pkg::PH_VER_LF:
            begin
                if (c == hrhp_pkg::CH_LF)
                begin
                    phase_next = hrhp_pkg::PH_LINE;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            hrhp_pkg::PH_LINE:
            begin
                if (c == hrhp_pkg::CH_CR)
                begin
                    phase_next = hrhp_pkg::PH_END_LF;
                end
                else if (c == hrhp_pkg::CH_LF || full)
                begin
                    bad = 1'b1;
                end
                else if (c == hrhp_pkg::CH_COLON)
                begin
                    idx        = cur_idx;
                    phase_next = hrhp_pkg::PH_COLON_SP;
                end
                else
                begin
                    idx        = cur_idx;
                    cls        = hrhp_pkg::CL_NAME;
                    phase_next = hrhp_pkg::PH_NAME;
                end
            end
            hrhp_pkg::PH_NAME:
            begin
                if (c == hrhp_pkg::CH_COLON)
                begin
                    idx        = cur_idx;
                    phase_next = hrhp_pkg::PH_COLON_SP;
                end
                else if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    idx = cur_idx;
                    cls = hrhp_pkg::CL_NAME;
                end
            end
            hrhp_pkg::PH_COLON_SP:
            begin
                if (c == hrhp_pkg::CH_SP)
                begin
                    idx        = cur_idx;
                    phase_next = hrhp_pkg::PH_SPACES;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            hrhp_pkg::PH_SPACES:
            begin
                if (c == hrhp_pkg::CH_SP)
                begin
                    idx = cur_idx;
                end
                else if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    idx        = cur_idx;
                    cls        = hrhp_pkg::CL_VALUE;
                    phase_next = hrhp_pkg::PH_VALUE;
                end
            end
            hrhp_pkg::PH_VALUE:
            begin
                idx = cur_idx;
                if (c == hrhp_pkg::CH_CR)
                begin
                    phase_next = hrhp_pkg::PH_VAL_LF;
                end
                else
                begin
                    cls = hrhp_pkg::CL_VALUE;
                end
            end
            hrhp_pkg::PH_VAL_LF:
            begin
                if (c == hrhp_pkg::CH_LF)
                begin
                    idx        = cur_idx;
                    count_next = count_reg + 1'b1;
                    phase_next = hrhp_pkg::PH_LINE;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            hrhp_pkg::PH_END_LF:
            begin
                if (c == hrhp_pkg::CH_LF)
                begin
                    phase_next = hrhp_pkg::PH_PAYLOAD;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            hrhp_pkg::PH_PAYLOAD:
            begin
                cls          = hrhp_pkg::CL_PAYLOAD;
                payload_byte = 1'b1;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
        if (bad)
        begin
            phase_next = hrhp_pkg::PH_ERROR;
            cls        = hrhp_pkg::CL_DELIM;
            idx        = '0;
        end
    end

    assign err_now  = error_reg || bad;
    assign res.cls  = cls;
    assign res.idx  = idx;
    assign res.err  = err_now;
    assign res.done = req.last;
    assign res.acc  = req.last && !err_now && payload_byte;

    // last byte re-arms for the next request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hrhp_pkg::PH_METHOD;
            count_reg <= '0;
            error_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (req.last)
            begin
                phase_reg <= hrhp_pkg::PH_METHOD;
                count_reg <= '0;
                error_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                error_reg <= err_now;
            end
        end
    end

endmodule

@@ design/hrhp_out_stage.sv @@
// ----------------------------------------------------------------------------
// hrhp_out_stage
// Result register: holds one classified byte until downstream takes it.
// ----------------------------------------------------------------------------
module hrhp_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  hrhp_pkg::res_t res_in,
    input  logic           res_stall,
    output logic           res_valid,
    output hrhp_pkg::res_t res_out,
    output logic           advance_ok
);

    logic           valid_reg;
    hrhp_pkg::res_t data_reg;

    assign advance_ok = !valid_reg || !res_stall;
    assign res_valid  = valid_reg;
    assign res_out    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= res_in;
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for http_request_head_parser_top. Sends whole and broken request
// heads byte by byte, predicts the class, header index, error flag and
// verdict of every byte, and checks each result against the oldest
// prediction. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_HDR    = hrhp_pkg::MAX_HEADERS_DEF;
    localparam int ITEMS      = 700;
    localparam int HOLD_LEN   = 300;
    localparam int IDLE_LIMIT = 3000;

    class byte_class_check;
        int                  max_hdr;
        hrhp_pkg::phase_t    ph;
        logic [5:0]          hdr_cnt;
        logic                err;
        hrhp_pkg::res_t      expected_q[$];
        int                  n_fail;
        int                  n_shown;

        function new(int hdr_limit);
            max_hdr = hdr_limit;
            n_fail  = 0;
            n_shown = 0;
            rearm();
        endfunction

        function void rearm();
            ph      = hrhp_pkg::PH_METHOD;
            hdr_cnt = '0;
            err     = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_TAB ||
                   c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF ||
                   c == hrhp_pkg::CH_VT || c == hrhp_pkg::CH_FF;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // classify one accepted request byte and queue the expected result
        function void note_request(logic [7:0] c, logic lst);
            hrhp_pkg::res_t   r;
            hrhp_pkg::phase_t nxt;
            bit               bad;
            bit               pay;
            r.cls = hrhp_pkg::CL_DELIM;
            r.idx = '0;
            nxt   = ph;
            bad   = 1'b0;
            pay   = 1'b0;
            case (ph)
                hrhp_pkg::PH_METHOD, hrhp_pkg::PH_URL:
                    if (c == hrhp_pkg::CH_SP)
                        nxt = (ph == hrhp_pkg::PH_METHOD) ? hrhp_pkg::PH_URL
                                                          : hrhp_pkg::PH_VERSION;
                    else if (is_blank(c))
                        bad = 1'b1;
                    else
                        r.cls = (ph == hrhp_pkg::PH_METHOD) ? hrhp_pkg::CL_METHOD
                                                            : hrhp_pkg::CL_URL;
                hrhp_pkg::PH_VERSION:
                    if (c == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_VER_LF;
                    else r.cls = hrhp_pkg::CL_VERSION;
                hrhp_pkg::PH_VER_LF:
                    if (c == hrhp_pkg::CH_LF) nxt = hrhp_pkg::PH_LINE;
                    else bad = 1'b1;
                hrhp_pkg::PH_LINE:
                    if (c == hrhp_pkg::CH_CR)
                        nxt = hrhp_pkg::PH_END_LF;
                    else if (c == hrhp_pkg::CH_LF || hdr_cnt >= max_hdr)
                        bad = 1'b1;
                    else if (c == hrhp_pkg::CH_COLON)
                    begin
                        r.idx = hdr_cnt[4:0];
                        nxt   = hrhp_pkg::PH_COLON_SP;
                    end
                    else
                    begin
                        r.idx = hdr_cnt[4:0];
                        r.cls = hrhp_pkg::CL_NAME;
                        nxt   = hrhp_pkg::PH_NAME;
                    end
                hrhp_pkg::PH_NAME:
                    if (c == hrhp_pkg::CH_COLON)
                    begin
                        r.idx = hdr_cnt[4:0];
                        nxt   = hrhp_pkg::PH_COLON_SP;
                    end
                    else if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF)
                        bad = 1'b1;
                    else
                    begin
                        r.idx = hdr_cnt[4:0];
                        r.cls = hrhp_pkg::CL_NAME;
                    end
                hrhp_pkg::PH_COLON_SP:
                    if (c == hrhp_pkg::CH_SP)
                    begin
                        r.idx = hdr_cnt[4:0];
                        nxt   = hrhp_pkg::PH_SPACES;
                    end
                    else
                        bad = 1'b1;
                hrhp_pkg::PH_SPACES:
                    if (c == hrhp_pkg::CH_SP)
                        r.idx = hdr_cnt[4:0];
                    else if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF)
                        bad = 1'b1;
                    else
                    begin
                        r.idx = hdr_cnt[4:0];
                        r.cls = hrhp_pkg::CL_VALUE;
                        nxt   = hrhp_pkg::PH_VALUE;
                    end
                hrhp_pkg::PH_VALUE:
                begin
                    r.idx = hdr_cnt[4:0];
                    if (c == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_VAL_LF;
                    else r.cls = hrhp_pkg::CL_VALUE;
                end
                hrhp_pkg::PH_VAL_LF:
                    if (c == hrhp_pkg::CH_LF)
                    begin
                        r.idx   = hdr_cnt[4:0];
                        hdr_cnt = hdr_cnt + 6'd1;
                        nxt     = hrhp_pkg::PH_LINE;
                    end
                    else
                        bad = 1'b1;
                hrhp_pkg::PH_END_LF:
                    if (c == hrhp_pkg::CH_LF) nxt = hrhp_pkg::PH_PAYLOAD;
                    else bad = 1'b1;
                hrhp_pkg::PH_PAYLOAD:
                begin
                    r.cls = hrhp_pkg::CL_PAYLOAD;
                    pay   = 1'b1;
                end
                default:
                    bad = 1'b1;
            endcase
            if (bad)
            begin
                err   = 1'b1;
                nxt   = hrhp_pkg::PH_ERROR;
                r.cls = hrhp_pkg::CL_DELIM;
                r.idx = '0;
            end
            ph     = nxt;
            r.err  = err;
            r.done = lst;
            r.acc  = lst && !err && pay;
            expected_q.push_back(r);
            if (lst)
                rearm();
        endfunction

        function void check_result(hrhp_pkg::res_t got);
            hrhp_pkg::res_t want;
            bit             bad;
            if (expected_q.size() == 0)
            begin
                n_fail++;
                if (n_shown < 10)
                begin
                    n_shown++;
                    $display("%0t: result with no request pending: cls=%0d idx=%0d",
                             $realtime, got.cls, got.idx);
                end
                return;
            end
            want = expected_q.pop_front();
            bad  = (got.cls !== want.cls) || (got.idx !== want.idx) ||
                   (got.err !== want.err) || (got.done !== want.done) ||
                   (got.acc !== want.acc);
            if (bad)
            begin
                n_fail++;
                if (n_shown < 10)
                begin
                    n_shown++;
                    $display("%0t: mismatch exp cls=%0d idx=%0d err=%0b done=%0b acc=%0b",
                             $realtime, want.cls, want.idx, want.err, want.done, want.acc);
                    $display("%0t:          got cls=%0d idx=%0d err=%0b done=%0b acc=%0b",
                             $realtime, got.cls, got.idx, got.err, got.done, got.acc);
                end
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    logic [7:0] byte_in   = 8'h00;
    logic       last      = 1'b0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [2:0] byte_class;
    logic [4:0] header_index;
    logic       error_seen;
    logic       done_res;
    logic       accepted;

    byte_class_check sb;
    bit [7:0]        msg[$];
    bit              idle_on;
    int              hold_cycles;
    int              n_sent;
    int              idle_cnt;

    http_request_head_parser_top #(
        .MAX_HEADERS_P (MAX_HDR)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .byte_in      (byte_in),
        .last         (last),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .byte_class   (byte_class),
        .header_index (header_index),
        .error_seen   (error_seen),
        .done_res     (done_res),
        .accepted     (accepted)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: one long hold-off, set by the stimulus, and random stall bursts
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                res_stall  <= 1'b1;
                stall_left = $urandom_range(1, 13) - 1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            hrhp_pkg::res_t got;
            bit             moved;
            moved = 1'b0;
            if (req_valid && !req_stall)
            begin
                sb.note_request(byte_in, last);
                moved = 1'b1;
            end
            if (res_valid && !res_stall)
            begin
                got.cls  = hrhp_pkg::class_t'(byte_class);
                got.idx  = header_index;
                got.err  = error_seen;
                got.done = done_res;
                got.acc  = accepted;
                sb.check_result(got);
                moved = 1'b1;
            end
            idle_cnt = moved ? 0 : idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("http_request_head_parser_top verification failed");
                $finish;
            end
        end
    end

    function automatic bit [7:0] rand_token_byte();
        bit [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (sb.is_blank(b));
        return b;
    endfunction

    function automatic bit [7:0] rand_byte_not(bit [7:0] a, bit [7:0] b2, bit [7:0] c);
        bit [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == a || b == b2 || b == c);
        return b;
    endfunction

    // well-formed request head with random content
    function automatic void build_request(int n_hdr);
        int n;
        msg.delete();
        n = $urandom_range(0, 4);
        repeat (n) msg.push_back(rand_token_byte());
        msg.push_back(hrhp_pkg::CH_SP);
        n = $urandom_range(0, 6);
        repeat (n) msg.push_back(rand_token_byte());
        msg.push_back(hrhp_pkg::CH_SP);
        n = $urandom_range(0, 5);
        repeat (n) msg.push_back(rand_byte_not(hrhp_pkg::CH_CR, hrhp_pkg::CH_CR,
                                               hrhp_pkg::CH_CR));
        msg.push_back(hrhp_pkg::CH_CR);
        msg.push_back(hrhp_pkg::CH_LF);
        for (int h = 0; h < n_hdr; h++)
        begin
            n = $urandom_range(0, 4);
            repeat (n) msg.push_back(rand_byte_not(hrhp_pkg::CH_COLON, hrhp_pkg::CH_CR,
                                                   hrhp_pkg::CH_LF));
            msg.push_back(hrhp_pkg::CH_COLON);
            n = $urandom_range(1, 3);
            repeat (n) msg.push_back(hrhp_pkg::CH_SP);
            msg.push_back(rand_byte_not(hrhp_pkg::CH_SP, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF));
            n = $urandom_range(0, 4);
            repeat (n) msg.push_back(rand_byte_not(hrhp_pkg::CH_CR, hrhp_pkg::CH_CR,
                                                   hrhp_pkg::CH_CR));
            msg.push_back(hrhp_pkg::CH_CR);
            msg.push_back(hrhp_pkg::CH_LF);
        end
        msg.push_back(hrhp_pkg::CH_CR);
        msg.push_back(hrhp_pkg::CH_LF);
        n = $urandom_range(1, 4);
        repeat (n) msg.push_back(8'($urandom_range(0, 255)));
    endfunction

    // short request head with many one-byte headers
    function automatic void build_dense_request(int n_hdr);
        msg.delete();
        msg.push_back(hrhp_pkg::CH_SP);
        msg.push_back(hrhp_pkg::CH_SP);
        msg.push_back(hrhp_pkg::CH_CR);
        msg.push_back(hrhp_pkg::CH_LF);
        for (int h = 0; h < n_hdr; h++)
        begin
            msg.push_back(8'h68);
            msg.push_back(hrhp_pkg::CH_COLON);
            msg.push_back(hrhp_pkg::CH_SP);
            msg.push_back(8'h76);
            msg.push_back(hrhp_pkg::CH_CR);
            msg.push_back(hrhp_pkg::CH_LF);
        end
        msg.push_back(hrhp_pkg::CH_CR);
        msg.push_back(hrhp_pkg::CH_LF);
        msg.push_back(8'h50);
    endfunction

    function automatic void break_request();
        bit [7:0] specials[7];
        int       pos;
        specials = '{hrhp_pkg::CH_SP, hrhp_pkg::CH_TAB, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF,
                     hrhp_pkg::CH_COLON, hrhp_pkg::CH_VT, hrhp_pkg::CH_FF};
        pos = $urandom_range(0, msg.size() - 1);
        case ($urandom_range(0, 3))
            0: msg[pos] = specials[$urandom_range(0, 6)];
            1: msg[pos] = 8'($urandom_range(0, 255));
            2: while (msg.size() > pos + 1) void'(msg.pop_back());
            default: if (msg.size() > 1) msg.delete(pos);
        endcase
    endfunction

    task automatic send_msg();
        for (int i = 0; i < msg.size(); i++)
        begin
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 13))
                begin
                    @(negedge clk);
                    req_valid <= 1'b0;
                end
            end
            @(negedge clk);
            req_valid <= 1'b1;
            byte_in   <= msg[i];
            last      <= (i == msg.size() - 1);
            @(posedge clk);
            while (req_stall) @(posedge clk);
        end
        n_sent += msg.size();
    endtask

    task automatic quiet_sender();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int n_msg;
        sb          = new(MAX_HDR);
        idle_on     = 1'b0;
        hold_cycles = 0;
        n_sent      = 0;
        idle_cnt    = 0;
        n_msg       = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty fields, nameless header, 0xFF value, NUL payload: accepted
        msg = '{hrhp_pkg::CH_SP, hrhp_pkg::CH_SP, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF,
                hrhp_pkg::CH_COLON, hrhp_pkg::CH_SP, 8'hFF, hrhp_pkg::CH_CR,
                hrhp_pkg::CH_LF, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF, 8'h00};
        send_msg();
        msg = '{8'h47, hrhp_pkg::CH_TAB, 8'h78};
        send_msg();
        msg = '{hrhp_pkg::CH_SP, hrhp_pkg::CH_VT, 8'h41};
        send_msg();
        msg = '{hrhp_pkg::CH_FF};
        send_msg();
        msg = '{hrhp_pkg::CH_CR, hrhp_pkg::CH_LF};
        send_msg();
        // LF at line start
        msg = '{hrhp_pkg::CH_SP, hrhp_pkg::CH_SP, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF,
                hrhp_pkg::CH_LF, 8'h61};
        send_msg();
        // early end
        msg = '{8'h47, 8'h45, 8'h54};
        send_msg();
        msg = '{hrhp_pkg::CH_SP, hrhp_pkg::CH_SP, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF,
                8'h6E, hrhp_pkg::CH_COLON, 8'h76};
        send_msg();
        // empty value
        msg = '{hrhp_pkg::CH_SP, hrhp_pkg::CH_SP, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF,
                hrhp_pkg::CH_COLON, hrhp_pkg::CH_SP, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF};
        send_msg();
        msg = '{hrhp_pkg::CH_SP, hrhp_pkg::CH_SP, hrhp_pkg::CH_CR, 8'h41};
        send_msg();
        // head ends with no payload
        msg = '{hrhp_pkg::CH_SP, hrhp_pkg::CH_SP, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF,
                hrhp_pkg::CH_CR, hrhp_pkg::CH_LF};
        send_msg();
        // header limit reached, then one header too many
        build_dense_request(MAX_HDR);
        send_msg();
        build_dense_request(MAX_HDR + 1);
        send_msg();

        while (n_sent < ITEMS * 85 / 100 || n_msg < 5)
        begin
            int pick;
            idle_on = ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 9);
            if (pick < 7)
                build_request($urandom_range(0, 4));
            else if (pick < 9)
            begin
                build_request($urandom_range(0, 3));
                break_request();
            end
            else
            begin
                msg.delete();
                repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(0, 255)));
            end
            n_msg++;
            if (n_msg == 2)
                hold_cycles = HOLD_LEN;
            if (n_msg == 4)
            begin
                quiet_sender();
                while (sb.pending() != 0) @(posedge clk);
            end
            send_msg();
        end

        idle_on = 1'b0;
        while (n_sent < ITEMS)
        begin
            build_request($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                break_request();
            send_msg();
        end

        quiet_sender();
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.n_fail == 0)
            $display("http_request_head_parser_top verification clean");
        else
            $display("http_request_head_parser_top verification failed");
        $finish;
    end

endmodule
